/* src/scdc_pkg.sv */
// Shared types, constants and helpers for the seconds and calendar date converter.
// Holds the request and response word layouts and the calendar tables.
// Depends on nothing; every other file in src imports it.
package scdc_pkg;

   // Width of the signed epoch offset register.
   localparam int OFFSET_W = 39;

   // Number of stage registers inside each converter pipeline.
   localparam int PIPE_DEPTH = 13;

   typedef logic signed [OFFSET_W-1:0] offset_type;

   // Request word: mode selects seconds-to-date (0) or date-to-seconds (1).
   typedef struct packed {
      logic        mode;
      logic [31:0] in_seconds;
      logic [13:0] in_year;
      logic [3:0]  in_month;
      logic [4:0]  in_day;
   } req_word_type;

   // Response word: date fields for mode 0, seconds and flag for mode 1.
   typedef struct packed {
      logic [13:0] out_year;
      logic [3:0]  out_month;
      logic [4:0]  out_day;
      logic [31:0] out_seconds;
      logic        out_clamped;
   } rsp_word_type;

   // Calendar constants on the March-based year.
   localparam logic [17:0] DAYS_PER_ERA  = 18'd146097;
   localparam logic [8:0]  DAYS_PER_YEAR = 9'd365;
   localparam logic [8:0]  YEARS_PER_ERA = 9'd400;

   // First day of each March-based month within its year.
   localparam logic [8:0] MONTH_START [12] = '{
      9'd0, 9'd31, 9'd61, 9'd92, 9'd122, 9'd153,
      9'd184, 9'd214, 9'd245, 9'd275, 9'd306, 9'd337
   };

   // Day-of-year offset of day one of a calendar month code 0 to 15. Month 0 is the
   // December before, months 13 and 14 fall in the next year and month 15 runs on.
   localparam logic [8:0] MONTH_OFFSET [16] = '{
      9'd275, 9'd306, 9'd337, 9'd0, 9'd31, 9'd61, 9'd92, 9'd122,
      9'd153, 9'd184, 9'd214, 9'd245, 9'd275, 9'd306, 9'd337, 9'd367
   };

   // Whole centuries in a year of era, valid for years 0 to 399.
   function automatic logic [1:0] century_of(input logic [8:0] yoe);
      logic [1:0] cent;
      cent = 2'd0;
      if (yoe >= 9'd100) begin
         cent = 2'd1;
      end
      if (yoe >= 9'd200) begin
         cent = 2'd2;
      end
      if (yoe >= 9'd300) begin
         cent = 2'd3;
      end
      return cent;
   endfunction

endpackage

/* src/scdc_s2d.sv */
// Seconds-to-date pipeline: adds the epoch offset, divides down to days and splits
// the day count into era, year, month and day. Depends on scdc_pkg.
module scdc_s2d (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  logic [31:0]            in_seconds,
   input  scdc_pkg::offset_type   offset,
   output logic                   out_valid,
   output scdc_pkg::rsp_word_type out_word
);
   import scdc_pkg::*;

   // Bias of 24 eras plus the Unix day shift, in seconds, keeps every sum positive.
   localparam logic [39:0] SEC_BIAS       = 40'd365108774400;
   localparam logic [9:0]  DIV_SEC        = 10'd675;     // 86400 / 128
   localparam logic [7:0]  RCP_SEC_HI     = 8'd194;      // floor(2^17 / 675)
   localparam logic [16:0] RCP_SEC_LO     = 17'd99420;   // floor(2^26 / 675)
   localparam logic [6:0]  RCP_ERA        = 7'd114;      // floor(2^24 / 146097)
   localparam logic [10:0] DAYS_PER_4Y    = 11'd1460;
   localparam logic [7:0]  RCP_4Y         = 8'd179;      // floor(2^18 / 1460)
   localparam logic [15:0] DAYS_PER_CENT  = 16'd36524;
   localparam logic [2:0]  RCP_CENT       = 3'd7;        // floor(2^18 / 36524)
   localparam logic [17:0] LAST_ERA_DAY   = 18'd146096;
   localparam logic [9:0]  RCP_YEAR       = 10'd718;     // floor(2^18 / 365)
   localparam logic [13:0] ERA_BIAS_YEARS = 14'd9600;

   logic [PIPE_DEPTH-1:0] vld_ff;

   logic [39:0] s1_w_ff, s1_w_in;
   logic [16:0] s2_a_ff;
   logic [15:0] s2_b_ff;
   logic [24:0] s2_pa_ff, s2_pa_in;
   logic [7:0]  s3_q0;
   logic [16:0] s3_rem;
   logic [7:0]  s3_qa_ff, s3_qa_in;
   logic [9:0]  s3_ra_ff, s3_ra_in;
   logic [15:0] s3_b_ff;
   logic [7:0]  s4_qa_ff;
   logic [25:0] s4_x_ff;
   logic [42:0] s4_px_ff, s4_px_in;
   logic [16:0] s5_q0, s5_qb;
   logic [25:0] s5_rem;
   logic [23:0] s5_zb_ff, s5_zb_in;
   logic [23:0] s6_zb_ff;
   logic [30:0] s6_pe_ff, s6_pe_in;
   logic [6:0]  s7_q0;
   logic [23:0] s7_rem;
   logic [6:0]  s7_era_ff, s7_era_in;
   logic [17:0] s7_doe_ff, s7_doe_in;
   logic [6:0]  s8_era_ff;
   logic [17:0] s8_doe_ff;
   logic [25:0] s8_p1_ff, s8_p1_in;
   logic [20:0] s8_p2_ff, s8_p2_in;
   logic [7:0]  s9_q0a, s9_q4y;
   logic [17:0] s9_rema, s9_remc;
   logic [2:0]  s9_q0c, s9_qc;
   logic [6:0]  s9_era_ff;
   logic [17:0] s9_doe_ff;
   logic [17:0] s9_tmp_ff, s9_tmp_in;
   logic [6:0]  s10_era_ff;
   logic [17:0] s10_doe_ff, s10_tmp_ff;
   logic [27:0] s10_pt_ff, s10_pt_in;
   logic [9:0]  s11_q0;
   logic [17:0] s11_rem;
   logic [6:0]  s11_era_ff;
   logic [17:0] s11_doe_ff;
   logic [8:0]  s11_yoe_ff, s11_yoe_in;
   logic [8:0]  s12_doy_ff, s12_doy_in;
   logic [13:0] s12_year_ff, s12_year_in;
   logic [3:0]  s13_mp;
   logic [4:0]  s13_day;
   rsp_word_type out_word_ff, out_word_in;

   // Valid bits travel alongside the data, one per stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[PIPE_DEPTH-2:0], in_valid};
      end
   end

   // Stage logic. Each division by a constant takes two stages: a reciprocal product,
   // then a remainder check that corrects the quotient by at most one.
   always_comb begin
      // Stage 1: biased Unix seconds, always positive and below 2^40.
      s1_w_in = 40'(in_seconds) + {offset[OFFSET_W-1], offset} + SEC_BIAS;

      // Stage 2: divide by 128 is a shift; the upper digit is multiplied by 1/675.
      s2_pa_in = 25'(s1_w_ff[39:23]) * 25'(RCP_SEC_HI);

      // Stage 3: correct the upper digit quotient.
      s3_q0  = s2_pa_ff[24:17];
      s3_rem = s2_a_ff - 17'(s3_q0) * 17'(DIV_SEC);
      if (s3_rem >= 17'(DIV_SEC)) begin
         s3_qa_in = s3_q0 + 8'd1;
         s3_ra_in = 10'(s3_rem - 17'(DIV_SEC));
      end else begin
         s3_qa_in = s3_q0;
         s3_ra_in = 10'(s3_rem);
      end

      // Stage 4: remainder and lower digit multiplied by 1/675.
      s4_px_in = 43'({s3_ra_ff, s3_b_ff}) * 43'(RCP_SEC_LO);

      // Stage 5: correct the lower digit and join both into the biased day count.
      s5_q0  = s4_px_ff[42:26];
      s5_rem = s4_x_ff - 26'(s5_q0) * 26'(DIV_SEC);
      s5_qb  = (s5_rem >= 26'(DIV_SEC)) ? s5_q0 + 17'd1 : s5_q0;
      s5_zb_in = {s4_qa_ff, s5_qb[15:0]};

      // Stage 6: era estimate.
      s6_pe_in = 31'(s5_zb_ff) * 31'(RCP_ERA);

      // Stage 7: correct the era and take the day of era.
      s7_q0  = s6_pe_ff[30:24];
      s7_rem = s6_zb_ff - 24'(s7_q0) * 24'(DAYS_PER_ERA);
      if (s7_rem >= 24'(DAYS_PER_ERA)) begin
         s7_era_in = s7_q0 + 7'd1;
         s7_doe_in = 18'(s7_rem - 24'(DAYS_PER_ERA));
      end else begin
         s7_era_in = s7_q0;
         s7_doe_in = 18'(s7_rem);
      end

      // Stage 8: estimates of four-year and century counts.
      s8_p1_in = 26'(s7_doe_ff) * 26'(RCP_4Y);
      s8_p2_in = 21'(s7_doe_ff) * 21'(RCP_CENT);

      // Stage 9: correct both and remove the leap days from the day of era.
      s9_q0a  = s8_p1_ff[25:18];
      s9_rema = s8_doe_ff - 18'(s9_q0a) * 18'(DAYS_PER_4Y);
      s9_q4y  = (s9_rema >= 18'(DAYS_PER_4Y)) ? s9_q0a + 8'd1 : s9_q0a;
      s9_q0c  = s8_p2_ff[20:18];
      s9_remc = s8_doe_ff - 18'(s9_q0c) * 18'(DAYS_PER_CENT);
      s9_qc   = (s9_remc >= 18'(DAYS_PER_CENT)) ? s9_q0c + 3'd1 : s9_q0c;
      s9_tmp_in = s8_doe_ff - 18'(s9_q4y) + 18'(s9_qc)
                - 18'(s8_doe_ff == LAST_ERA_DAY);

      // Stage 10: year of era estimate.
      s10_pt_in = 28'(s9_tmp_ff) * 28'(RCP_YEAR);

      // Stage 11: correct the year of era.
      s11_q0  = s10_pt_ff[27:18];
      s11_rem = s10_tmp_ff - 18'(s11_q0) * 18'(DAYS_PER_YEAR);
      s11_yoe_in = (s11_rem >= 18'(DAYS_PER_YEAR)) ? 9'(s11_q0 + 10'd1) : 9'(s11_q0);

      // Stage 12: day of the March-based year and the year, wrapped to 14 bits.
      s12_doy_in = 9'(s11_doe_ff - (18'(s11_yoe_ff) * 18'(DAYS_PER_YEAR)
                 + 18'(s11_yoe_ff[8:2]) - 18'(century_of(s11_yoe_ff))));
      s12_year_in = 14'(s11_yoe_ff) + 14'(s11_era_ff) * 14'(YEARS_PER_ERA)
                  - ERA_BIAS_YEARS;

      // Stage 13: month by comparison against the month starts, then the day.
      s13_mp = 4'd0;
      for (int k = 1; k < 12; k++) begin
         if (s12_doy_ff >= MONTH_START[k]) begin
            s13_mp = s13_mp + 4'd1;
         end
      end
      s13_day = 5'(s12_doy_ff - MONTH_START[s13_mp] + 9'd1);
      out_word_in.out_year    = s12_year_ff + 14'(s13_mp >= 4'd10);
      out_word_in.out_month   = (s13_mp < 4'd10) ? s13_mp + 4'd3 : s13_mp - 4'd9;
      out_word_in.out_day     = s13_day;
      out_word_in.out_seconds = '0;
      out_word_in.out_clamped = 1'b0;
   end

   // Data registers; the valid bits say which of them hold a word.
   always_ff @(posedge clock) begin
      s1_w_ff     <= s1_w_in;
      s2_a_ff     <= s1_w_ff[39:23];
      s2_b_ff     <= s1_w_ff[22:7];
      s2_pa_ff    <= s2_pa_in;
      s3_qa_ff    <= s3_qa_in;
      s3_ra_ff    <= s3_ra_in;
      s3_b_ff     <= s2_b_ff;
      s4_qa_ff    <= s3_qa_ff;
      s4_x_ff     <= {s3_ra_ff, s3_b_ff};
      s4_px_ff    <= s4_px_in;
      s5_zb_ff    <= s5_zb_in;
      s6_zb_ff    <= s5_zb_ff;
      s6_pe_ff    <= s6_pe_in;
      s7_era_ff   <= s7_era_in;
      s7_doe_ff   <= s7_doe_in;
      s8_era_ff   <= s7_era_ff;
      s8_doe_ff   <= s7_doe_ff;
      s8_p1_ff    <= s8_p1_in;
      s8_p2_ff    <= s8_p2_in;
      s9_era_ff   <= s8_era_ff;
      s9_doe_ff   <= s8_doe_ff;
      s9_tmp_ff   <= s9_tmp_in;
      s10_era_ff  <= s9_era_ff;
      s10_doe_ff  <= s9_doe_ff;
      s10_tmp_ff  <= s9_tmp_ff;
      s10_pt_ff   <= s10_pt_in;
      s11_era_ff  <= s10_era_ff;
      s11_doe_ff  <= s10_doe_ff;
      s11_yoe_ff  <= s11_yoe_in;
      s12_doy_ff  <= s12_doy_in;
      s12_year_ff <= s12_year_in;
      out_word_ff <= out_word_in;
   end

   assign out_valid = vld_ff[PIPE_DEPTH-1];
   assign out_word  = out_word_ff;

endmodule

/* src/scdc_d2s.sv */
// Date-to-seconds pipeline: turns a calendar date into a day count, scales it to
// seconds, removes the epoch offset and clamps to 32 bits. Depends on scdc_pkg.
module scdc_d2s (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  logic [13:0]            in_year,
   input  logic [3:0]             in_month,
   input  logic [4:0]             in_day,
   input  scdc_pkg::offset_type   offset,
   output logic                   out_valid,
   output scdc_pkg::rsp_word_type out_word
);
   import scdc_pkg::*;

   localparam int          CORE_DEPTH   = 8;
   localparam int          PAD_DEPTH    = PIPE_DEPTH - CORE_DEPTH;
   localparam logic [6:0]  RCP_ERA_Y    = 7'd81;        // floor(2^15 / 400)
   localparam logic [24:0] DAYS_BIAS    = 25'd865565;   // one era plus the Unix day shift
   localparam logic [16:0] SECS_PER_DAY = 17'd86400;

   logic [PIPE_DEPTH-1:0] vld_ff;

   logic [14:0] s1_ys_ff, s1_ys_in;
   logic [3:0]  s1_month_ff, s2_month_ff, s3_month_ff;
   logic [4:0]  s1_day_ff, s2_day_ff, s3_day_ff;
   logic [14:0] s2_ys_ff;
   logic [21:0] s2_p_ff, s2_p_in;
   logic [6:0]  s3_q0;
   logic [14:0] s3_rem;
   logic [5:0]  s3_era_ff, s3_era_in;
   logic [8:0]  s3_yoe_ff, s3_yoe_in;
   logic [18:0] s4_doe_ff, s4_doe_in;
   logic [22:0] s4_erd_ff, s4_erd_in;
   logic [24:0] s5_days_ff, s5_days_in;
   logic [41:0] s6_prod_ff, s6_prod_in;
   logic [42:0] s7_boot_ff, s7_boot_in;
   rsp_word_type s8_word_ff, s8_word_in;
   rsp_word_type pad_ff [PAD_DEPTH];

   // Valid bits travel alongside the data, one per stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[PIPE_DEPTH-2:0], in_valid};
      end
   end

   always_comb begin
      // Stage 1: January and February belong to the year before; one era of bias
      // keeps year zero's predecessor positive.
      s1_ys_in = 15'(in_year) + 15'(YEARS_PER_ERA) - 15'(in_month <= 4'd2);

      // Stage 2: era estimate.
      s2_p_in = 22'(s1_ys_ff) * 22'(RCP_ERA_Y);

      // Stage 3: correct the era and take the year of era.
      s3_q0  = s2_p_ff[21:15];
      s3_rem = s2_ys_ff - 15'(s3_q0) * 15'(YEARS_PER_ERA);
      if (s3_rem >= 15'(YEARS_PER_ERA)) begin
         s3_era_in = 6'(s3_q0 + 7'd1);
         s3_yoe_in = 9'(s3_rem - 15'(YEARS_PER_ERA));
      end else begin
         s3_era_in = 6'(s3_q0);
         s3_yoe_in = 9'(s3_rem);
      end

      // Stage 4: day of era (may be minus one) and the era's first day.
      s4_doe_in = 19'(s3_yoe_ff) * 19'(DAYS_PER_YEAR) + 19'(s3_yoe_ff[8:2])
                - 19'(century_of(s3_yoe_ff)) + 19'(MONTH_OFFSET[s3_month_ff])
                + 19'(s3_day_ff) - 19'd1;
      s4_erd_in = 23'(s3_era_ff) * 23'(DAYS_PER_ERA);

      // Stage 5: signed days since the Unix epoch.
      s5_days_in = 25'(s4_erd_ff) + {{6{s4_doe_ff[18]}}, s4_doe_ff} - DAYS_BIAS;

      // Stage 6: scale to seconds in two's complement.
      s6_prod_in = {{17{s5_days_ff[24]}}, s5_days_ff} * 42'(SECS_PER_DAY);

      // Stage 7: seconds since boot.
      s7_boot_in = {s6_prod_ff[41], s6_prod_ff}
                 - {{(43 - OFFSET_W){offset[OFFSET_W-1]}}, offset};

      // Stage 8: clamp at zero and saturate at the 32-bit maximum.
      s8_word_in.out_year  = '0;
      s8_word_in.out_month = '0;
      s8_word_in.out_day   = '0;
      if (s7_boot_ff[42] || s7_boot_ff == '0) begin
         s8_word_in.out_seconds = '0;
         s8_word_in.out_clamped = 1'b1;
      end else if (s7_boot_ff[41:32] != '0) begin
         s8_word_in.out_seconds = '1;
         s8_word_in.out_clamped = 1'b1;
      end else begin
         s8_word_in.out_seconds = s7_boot_ff[31:0];
         s8_word_in.out_clamped = 1'b0;
      end
   end

   // Data registers, then a delay line that matches the seconds-to-date latency.
   always_ff @(posedge clock) begin
      s1_ys_ff    <= s1_ys_in;
      s1_month_ff <= in_month;
      s1_day_ff   <= in_day;
      s2_ys_ff    <= s1_ys_ff;
      s2_p_ff     <= s2_p_in;
      s2_month_ff <= s1_month_ff;
      s2_day_ff   <= s1_day_ff;
      s3_era_ff   <= s3_era_in;
      s3_yoe_ff   <= s3_yoe_in;
      s3_month_ff <= s2_month_ff;
      s3_day_ff   <= s2_day_ff;
      s4_doe_ff   <= s4_doe_in;
      s4_erd_ff   <= s4_erd_in;
      s5_days_ff  <= s5_days_in;
      s6_prod_ff  <= s6_prod_in;
      s7_boot_ff  <= s7_boot_in;
      s8_word_ff  <= s8_word_in;
      pad_ff[0]   <= s8_word_ff;
      for (int k = 1; k < PAD_DEPTH; k++) begin
         pad_ff[k] <= pad_ff[k-1];
      end
   end

   assign out_valid = vld_ff[PIPE_DEPTH-1];
   assign out_word  = pad_ff[PAD_DEPTH-1];

endmodule

/* src/seconds_calendar_date_converter.sv */
// Seconds and calendar date converter, top level.
// The response strobe and word come out of 13 converter stages and one output register.
// Throughput: one word a cycle; busy is always low and responses leave one a cycle.
// Reset clears the pipeline valid bits, the strobe and the epoch offset to zero.
// Depends on scdc_pkg, scdc_s2d and scdc_d2s.
module seconds_calendar_date_converter (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  scdc_pkg::req_word_type req_word,
   input  logic                   csr_write_en,
   input  scdc_pkg::offset_type   csr_write_data,
   output logic                   rsp_strobe,
   output scdc_pkg::rsp_word_type rsp_word
);
   import scdc_pkg::*;

   offset_type   csr_offset_ff;
   logic         s2d_valid, d2s_valid;
   rsp_word_type s2d_word, d2s_word;
   logic         rsp_strobe_ff, rsp_strobe_in;
   rsp_word_type rsp_word_ff, rsp_word_in;

   // Epoch offset register; user writes it only while pipeline is empty, not enforced.
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_offset_ff <= '0;
      end else if (csr_write_en) begin
         csr_offset_ff <= csr_write_data;
      end
   end

   // Both pipelines have the same depth, so at most one of them finishes a word
   // in any cycle.
   scdc_s2d u_s2d (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (start && !req_word.mode),
      .in_seconds (req_word.in_seconds),
      .offset     (csr_offset_ff),
      .out_valid  (s2d_valid),
      .out_word   (s2d_word)
   );

   scdc_d2s u_d2s (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (start && req_word.mode),
      .in_year    (req_word.in_year),
      .in_month   (req_word.in_month),
      .in_day     (req_word.in_day),
      .offset     (csr_offset_ff),
      .out_valid  (d2s_valid),
      .out_word   (d2s_word)
   );

   // Output register merging the two pipelines.
   always_comb begin
      rsp_strobe_in = s2d_valid || d2s_valid;
      rsp_word_in   = s2d_valid ? s2d_word : d2s_word;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   assign busy       = 1'b0;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_word_ff;

endmodule

/* test/tb_top.sv */
// Self-checking testbench for the seconds and calendar date converter.
// Sends request words in both modes under several epoch offsets and checks every response
// word against a behavioural calendar model; depends on scdc_pkg and the converter RTL.
module tb_top;
   import scdc_pkg::*;

   localparam int     LATENCY         = 14;
   localparam int     ITEMS_PER_PHASE = 190;
   localparam int     PHASE_COUNT     = 8;
   localparam int     NO_IDLE_PHASE   = 3;
   localparam longint SECS_PER_DAY    = 64'sd86400;
   localparam longint DAYS_PER_ERA    = 64'sd146097;
   localparam longint DAYS_TO_EPOCH   = 64'sd719468;
   localparam longint SECONDS_MAX     = 64'sd4294967295;
   localparam longint OFFSET_LOW      = -64'sd62167219200;
   localparam longint OFFSET_HIGH     = 64'sd253402300799;

   // Calendar model with its own copy of the epoch offset and the words still to come.
   class calendar_scoreboard;
      longint       epoch_offset;
      rsp_word_type awaited_words [$];
      int           error_count;

      function longint floor_quot(longint a, longint b);
         return (a >= 0) ? a / b : (a - (b - 1)) / b;
      endfunction

      // Works out the response word that one request word should give.
      function rsp_word_type convert_word(req_word_type w);
         rsp_word_type r;
         longint z, era, doe, yoe, doy, mp, yr, mo, y, m, d, days, boot;
         r = '0;
         if (w.mode == 1'b0) begin
            // Seconds to date on the March-based year of 400-year eras.
            z   = floor_quot(longint'(w.in_seconds) + epoch_offset, SECS_PER_DAY)
                  + DAYS_TO_EPOCH;
            era = floor_quot(z, DAYS_PER_ERA);
            doe = z - era * DAYS_PER_ERA;
            yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
            yr  = yoe + era * 400;
            doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
            mp  = (5 * doy + 2) / 153;
            d   = doy - (153 * mp + 2) / 5 + 1;
            mo  = (mp < 10) ? mp + 3 : mp - 9;
            if (mo <= 2) begin
               yr = yr + 1;
            end
            r.out_year  = yr[13:0];
            r.out_month = mo[3:0];
            r.out_day   = d[4:0];
         end else begin
            // Date to seconds; odd months and days simply run on from the table.
            y = longint'(w.in_year);
            m = longint'(w.in_month);
            d = longint'(w.in_day);
            if (m <= 2) begin
               y = y - 1;
            end
            era  = floor_quot(y, 400);
            yoe  = y - era * 400;
            mp   = (m > 2) ? m - 3 : m + 9;
            doy  = (153 * mp + 2) / 5 + d - 1;
            doe  = yoe * 365 + yoe / 4 - yoe / 100 + doy;
            days = era * DAYS_PER_ERA + doe - DAYS_TO_EPOCH;
            boot = days * SECS_PER_DAY - epoch_offset;
            if (boot <= 0) begin
               r.out_clamped = 1'b1;
            end else if (boot > SECONDS_MAX) begin
               r.out_seconds = '1;
               r.out_clamped = 1'b1;
            end else begin
               r.out_seconds = boot[31:0];
            end
         end
         return r;
      endfunction

      function void note_request(req_word_type w);
         awaited_words.push_back(convert_word(w));
      endfunction

      function void check_response(rsp_word_type got);
         rsp_word_type want;
         if (awaited_words.size() == 0) begin
            $error("response word %h arrived with none awaited", got);
            error_count++;
            return;
         end
         want = awaited_words.pop_front();
         if (got.out_year !== want.out_year) begin
            $error("out_year: expected %0d, got %0d", want.out_year, got.out_year);
            error_count++;
         end
         if (got.out_month !== want.out_month) begin
            $error("out_month: expected %0d, got %0d", want.out_month, got.out_month);
            error_count++;
         end
         if (got.out_day !== want.out_day) begin
            $error("out_day: expected %0d, got %0d", want.out_day, got.out_day);
            error_count++;
         end
         if (got.out_seconds !== want.out_seconds) begin
            $error("out_seconds: expected %0d, got %0d", want.out_seconds, got.out_seconds);
            error_count++;
         end
         if (got.out_clamped !== want.out_clamped) begin
            $error("out_clamped: expected %0d, got %0d", want.out_clamped, got.out_clamped);
            error_count++;
         end
      endfunction
   endclass

   logic         clock = 1'b0;
   logic         reset;
   logic         start;
   logic         busy;
   req_word_type req_word;
   logic         csr_write_en;
   offset_type   csr_write_data;
   logic         rsp_strobe;
   rsp_word_type rsp_word;

   calendar_scoreboard board = new;

   seconds_calendar_date_converter u_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_word       (req_word),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .rsp_strobe     (rsp_strobe),
      .rsp_word       (rsp_word)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Every strobed response word is taken at the edge that ends its cycle.
   always @(posedge clock) begin
      if (!reset && rsp_strobe === 1'b1) begin
         board.check_response(rsp_word);
      end
   end

   // Unused fields carry random values so that the block is seen to ignore them.
   function automatic req_word_type seconds_word(longint s);
      req_word_type w;
      w.mode       = 1'b0;
      w.in_seconds = s[31:0];
      w.in_year    = 14'($urandom_range(0, 16383));
      w.in_month   = 4'($urandom_range(0, 15));
      w.in_day     = 5'($urandom_range(0, 31));
      return w;
   endfunction

   function automatic req_word_type date_word(int y, int m, int d);
      req_word_type w;
      w.mode       = 1'b1;
      w.in_seconds = $urandom;
      w.in_year    = y[13:0];
      w.in_month   = m[3:0];
      w.in_day     = d[4:0];
      return w;
   endfunction

   // Mostly dates near the current boot window and seconds near midnight, plus noise.
   function automatic req_word_type random_word(int base_year, longint day_phase);
      int unsigned pick;
      longint      s;
      int          yr;
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
         if (pick < 20) begin
            s = longint'($urandom);
         end else if (pick < 46) begin
            s = longint'($urandom_range(0, 49710)) * SECS_PER_DAY - day_phase
                + longint'($urandom_range(0, 2)) - 1;
         end else if (pick < 48) begin
            s = 0;
         end else begin
            s = SECONDS_MAX;
         end
         return seconds_word(s);
      end
      if (pick < 80) begin
         yr = base_year - 2 + int'($urandom_range(0, 139));
         if (yr < 0) begin
            yr = 0;
         end else if (yr > 9999) begin
            yr = 9999 - int'($urandom_range(0, 30));
         end
      end else if (pick < 93) begin
         yr = $urandom_range(0, 9999);
      end else begin
         yr = $urandom_range(0, 16383);
      end
      if ($urandom_range(0, 99) < 85) begin
         return date_word(yr, $urandom_range(1, 12), $urandom_range(1, 28));
      end
      return date_word(yr, $urandom_range(0, 15), $urandom_range(0, 31));
   endfunction

   // Any 39-bit value within the offset's range.
   function automatic longint random_offset();
      longint v;
      do begin
         v = longint'({$urandom, $urandom});
         v = (v <<< 25) >>> 25;
      end while (v < OFFSET_LOW || v > OFFSET_HIGH);
      return v;
   endfunction

   // Holds start high until the block takes the word.
   task automatic send_word(req_word_type w);
      start    <= 1'b1;
      req_word <= w;
      @(posedge clock);
      while (busy) begin
         @(posedge clock);
      end
      board.note_request(w);
   endtask

   // Short random idle gaps after about 11 words in a hundred.
   task automatic idle_gap(bit allowed);
      if (allowed && $urandom_range(0, 99) < 11) begin
         start               <= 1'b0;
         req_word.in_seconds <= $urandom;
         repeat ($urandom_range(1, 2)) @(posedge clock);
      end
   endtask

   // Waits for every awaited word, with a bound, then lets the pipeline settle.
   task automatic drain_responses();
      int waited;
      waited = 0;
      while (board.awaited_words.size() != 0 && waited < 20 * LATENCY) begin
         @(posedge clock);
         waited++;
      end
      repeat (LATENCY + 2) @(posedge clock);
   endtask

   task automatic write_offset(longint v);
      csr_write_en   <= 1'b1;
      csr_write_data <= v[38:0];
      @(posedge clock);
      csr_write_en       <= 1'b0;
      board.epoch_offset  = v;
   endtask

   initial begin
      req_word_type directed [$];
      longint       phase_offsets [PHASE_COUNT];
      rsp_word_type probe_date;
      longint       day_phase;
      int           base_year;
      reset          <= 1'b1;
      start          <= 1'b0;
      req_word       <= '0;
      csr_write_en   <= 1'b0;
      csr_write_data <= '0;
      board.epoch_offset = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed words under the reset offset: day and leap boundaries, the 32-bit
      // ends, clamping at and below zero, saturation, and months and days off the table.
      directed = '{
         seconds_word(0), seconds_word(1), seconds_word(86399), seconds_word(86400),
         seconds_word(951782400), seconds_word(951868800), seconds_word(68169600),
         seconds_word(2147483648), seconds_word(SECONDS_MAX),
         date_word(1970, 1, 1), date_word(1970, 1, 2), date_word(0, 1, 1),
         date_word(9999, 12, 31), date_word(2106, 2, 7), date_word(2106, 2, 8),
         date_word(2000, 2, 29), date_word(1900, 3, 1), date_word(2024, 0, 15),
         date_word(2024, 13, 1), date_word(2024, 14, 29), date_word(2024, 15, 31),
         date_word(2023, 3, 0), date_word(2023, 2, 31), date_word(16383, 15, 31),
         date_word(0, 0, 0)
      };
      foreach (directed[i]) begin
         send_word(directed[i]);
         idle_gap(1'b1);
      end

      // Random phases, each under its own offset; both range ends come first.
      phase_offsets[0] = OFFSET_LOW;
      phase_offsets[1] = OFFSET_HIGH;
      phase_offsets[2] = 0;
      phase_offsets[3] = 64'sd1700000000;
      phase_offsets[4] = -64'sd1;
      for (int p = 5; p < PHASE_COUNT; p++) begin
         phase_offsets[p] = random_offset();
      end

      for (int p = 0; p < PHASE_COUNT; p++) begin
         start <= 1'b0;
         drain_responses();
         write_offset(phase_offsets[p]);
         probe_date = board.convert_word(seconds_word(0));
         base_year  = int'(probe_date.out_year);
         day_phase  = phase_offsets[p]
                      - board.floor_quot(phase_offsets[p], SECS_PER_DAY) * SECS_PER_DAY;
         for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
            send_word(random_word(base_year, day_phase));
            idle_gap(p != NO_IDLE_PHASE);
         end
      end

      start <= 1'b0;
      drain_responses();
      if (board.awaited_words.size() != 0) begin
         $error("%0d response words never arrived", board.awaited_words.size());
         board.error_count++;
      end
      if (board.error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // Guard against a hung handshake.
   initial begin
      #2000000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
